[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while in reset.
`define SFSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Clocked check that also runs during reset.
`define SFSP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: check failed");

`endif

[rtl/core/sfsp_pkg.sv]
`default_nettype none
package sfsp_pkg;

  localparam logic [7:0] HdrFirst  = 8'h32;
  localparam logic [7:0] HdrSecond = 8'h3D;
  localparam logic [5:0] PosStart  = 6'd2;
  localparam logic [5:0] PosPm25Hi = 6'd12;
  localparam logic [5:0] PosPm25Lo = 6'd13;
  localparam logic [5:0] PosPm10Hi = 6'd14;
  localparam logic [5:0] PosPm10Lo = 6'd15;
  localparam logic [5:0] PosSumHi  = 6'd30;
  localparam logic [5:0] PosLast   = 6'd31;
  localparam logic [12:0] HdrSum   = 13'(HdrFirst) + 13'(HdrSecond);

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [15:0] half_t;
  typedef logic [12:0] sum_t;
  typedef logic [5:0]  pos_t;

endpackage
`default_nettype wire

[rtl/core/sensor_frame_sum_checked_parser_unit.sv]
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid_i / in_stall_o  | rx_byte_i, time_ms_i
// result  | out       | out_valid_o / out_stall_i | frame_good_o, pm25_value_o,
//         |           |                        | pm10_value_o, packet_time_ms_o,
//         |           |                        | error_total_o
// One byte per cycle sustained while no last byte is stalled; a byte is
// registered, then parsed, and a frame result is registered at the end of the
// same cycle in which its last byte is parsed.
// Reset clears frame tracking and the error count; no clearing pass.
// A stalled result blocks only a following last byte and the input behind it; other bytes keep flowing.
`default_nettype none
module sensor_frame_sum_checked_parser_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  sfsp_pkg::byte_t     rx_byte_i,
  input  sfsp_pkg::word_t     time_ms_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic                frame_good_o,
  output sfsp_pkg::half_t     pm25_value_o,
  output sfsp_pkg::half_t     pm10_value_o,
  output sfsp_pkg::word_t     packet_time_ms_o,
  output sfsp_pkg::word_t     error_total_o
);
  import sfsp_pkg::*;

  // input register
  logic  s1_valid_q;
  byte_t s1_byte_q;
  word_t s1_time_q;

  // parser state
  logic  inside_q, inside_d;
  pos_t  pos_q, pos_d;
  byte_t prev_q, prev_d;
  sum_t  sum_q, sum_d;
  half_t pm25_q, pm25_d;
  half_t pm10_q, pm10_d;
  byte_t sent_hi_q, sent_hi_d;
  word_t err_q, err_d;

  // result register
  logic  out_valid_q, out_valid_d;
  logic  good_q, good_d;
  half_t res_pm25_q, res_pm25_d;
  half_t res_pm10_q, res_pm10_d;
  word_t res_time_q, res_time_d;
  word_t res_err_q, res_err_d;

  logic  is_last;
  logic  s1_fire;
  logic  res_fire;
  logic  sum_ok;
  logic  in_xfer;

  assign is_last    = inside_q && (pos_q >= PosLast);
  assign in_stall_o = s1_valid_q && is_last && out_valid_q && out_stall_i;
  assign s1_fire    = s1_valid_q && !in_stall_o;
  assign res_fire   = s1_fire && is_last;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign sum_ok     = {3'b000, sum_q} == {sent_hi_q, s1_byte_q};

  always_comb begin
    inside_d  = inside_q;
    pos_d     = pos_q;
    prev_d    = prev_q;
    sum_d     = sum_q;
    pm25_d    = pm25_q;
    pm10_d    = pm10_q;
    sent_hi_d = sent_hi_q;
    err_d     = err_q;
    if (s1_fire) begin
      if (!inside_q) begin
        if (prev_q == HdrFirst && s1_byte_q == HdrSecond) begin
          inside_d = 1'b1;
          pos_d    = PosStart;
          sum_d    = HdrSum;
        end
        prev_d = s1_byte_q;
      end else if (!is_last) begin
        if (pos_q < PosSumHi) begin
          sum_d = sum_q + sum_t'(s1_byte_q);
        end
        case (pos_q)
          PosPm25Hi: pm25_d[15:8] = s1_byte_q;
          PosPm25Lo: pm25_d[7:0]  = s1_byte_q;
          PosPm10Hi: pm10_d[15:8] = s1_byte_q;
          PosPm10Lo: pm10_d[7:0]  = s1_byte_q;
          PosSumHi:  sent_hi_d    = s1_byte_q;
          default:   ;
        endcase
        pos_d = pos_q + pos_t'(1);
      end else begin
        if (!sum_ok) begin
          err_d = err_q + word_t'(1);
        end
        inside_d = 1'b0;
        pos_d    = '0;
        prev_d   = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    good_d      = good_q;
    res_pm25_d  = res_pm25_q;
    res_pm10_d  = res_pm10_q;
    res_time_d  = res_time_q;
    res_err_d   = res_err_q;
    if (res_fire) begin
      out_valid_d = 1'b1;
      good_d      = sum_ok;
      res_pm25_d  = sum_ok ? pm25_q : '0;
      res_pm10_d  = sum_ok ? pm10_q : '0;
      res_time_d  = s1_time_q;
      res_err_d   = err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      inside_q    <= 1'b0;
      pos_q       <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      inside_q    <= inside_d;
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      sum_q       <= sum_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= rx_byte_i;
      s1_time_q <= time_ms_i;
    end
    pm25_q     <= pm25_d;
    pm10_q     <= pm10_d;
    sent_hi_q  <= sent_hi_d;
    good_q     <= good_d;
    res_pm25_q <= res_pm25_d;
    res_pm10_q <= res_pm10_d;
    res_time_q <= res_time_d;
    res_err_q  <= res_err_d;
  end

  assign out_valid_o      = out_valid_q;
  assign frame_good_o     = good_q;
  assign pm25_value_o     = res_pm25_q;
  assign pm10_value_o     = res_pm10_q;
  assign packet_time_ms_o = res_time_q;
  assign error_total_o    = res_err_q;

`include "assert_macros.svh"

  // a bad frame bumps the error count by exactly one
  `SFSP_ASSERT(a_err_step, (res_fire && !sum_ok) |=> (err_q == $past(err_q) + word_t'(1)))
  // a good frame leaves the error count alone
  `SFSP_ASSERT(a_err_hold, (res_fire && sum_ok) |=> $stable(err_q))
  // bad results carry zeroed readings
  `SFSP_ASSERT(a_bad_zero, (out_valid_q && !good_q) |-> (res_pm25_q == '0 && res_pm10_q == '0))
  // position stays within the frame while collecting
  `SFSP_ASSERT(a_pos_range, inside_q |-> (pos_q >= PosStart && pos_q <= PosLast))
  // stall only ever holds a pending byte
  `SFSP_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> (s1_valid_q && out_valid_q))

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import sfsp_pkg::*;

  typedef struct packed {
    logic  good;
    half_t pm25;
    half_t pm10;
    word_t stamp;
    word_t errs;
  } frame_res_t;

  // one directed frame: lead byte, data fill, readings, stamp of byte 31,
  // checksum corruption, and the typed-in result where it is obvious
  typedef struct packed {
    byte_t lead;
    byte_t fill;
    half_t pm25;
    half_t pm10;
    word_t stamp;
    half_t sum_flip;
    logic  typed;
    logic  exp_good;
    half_t exp_pm25;
    half_t exp_pm10;
    word_t exp_errs;
  } plan_row_t;

  localparam int PlanRows   = 7;
  localparam int RandBytes  = 1600;
  localparam int HoldCycles = 300;
  localparam int MaxReports = 10;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  byte_t rx_byte_i;
  word_t time_ms_i;
  logic  out_valid_o;
  logic  out_stall_i;
  logic  frame_good_o;
  half_t pm25_value_o;
  half_t pm10_value_o;
  word_t packet_time_ms_o;
  word_t error_total_o;

  sensor_frame_sum_checked_parser_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .time_ms_i        (time_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_good_o     (frame_good_o),
    .pm25_value_o     (pm25_value_o),
    .pm10_value_o     (pm10_value_o),
    .packet_time_ms_o (packet_time_ms_o),
    .error_total_o    (error_total_o)
  );

  // parser state mirror
  logic  in_frame;
  pos_t  frame_pos;
  byte_t last_byte;
  sum_t  sum_acc;
  half_t pm25_acc;
  half_t pm10_acc;
  byte_t sum_hi_rx;
  word_t bad_frames;

  frame_res_t frames_due[$];
  plan_row_t  plan [PlanRows];
  byte_t      frame_buf [32];
  int         mismatches;
  logic       quiet;
  logic       hold_req;
  int         hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // returns 1 when the byte closes a frame
  function automatic logic parse_byte(input byte_t b, input word_t t, output frame_res_t r);
    half_t sent;
    logic  ok;
    r = '0;
    if (!in_frame) begin
      if (last_byte == HdrFirst && b == HdrSecond) begin
        in_frame  = 1'b1;
        frame_pos = PosStart;
        sum_acc   = HdrSum;
      end
      last_byte = b;
      return 1'b0;
    end
    if (frame_pos < PosLast) begin
      if (frame_pos < PosSumHi) sum_acc = sum_acc + sum_t'(b);
      case (frame_pos)
        PosPm25Hi: pm25_acc[15:8] = b;
        PosPm25Lo: pm25_acc[7:0]  = b;
        PosPm10Hi: pm10_acc[15:8] = b;
        PosPm10Lo: pm10_acc[7:0]  = b;
        PosSumHi:  sum_hi_rx      = b;
        default: ;
      endcase
      frame_pos = frame_pos + 6'd1;
      return 1'b0;
    end
    sent = {sum_hi_rx, b};
    ok   = (half_t'(sum_acc) == sent);
    if (!ok) bad_frames = bad_frames + 32'd1;
    r.good  = ok;
    r.pm25  = ok ? pm25_acc : 16'h0000;
    r.pm10  = ok ? pm10_acc : 16'h0000;
    r.stamp = t;
    r.errs  = bad_frames;
    in_frame  = 1'b0;
    frame_pos = '0;
    last_byte = '0;
    return 1'b1;
  endfunction

  task automatic push_byte(input byte_t b, input word_t t);
    frame_res_t r;
    while (!quiet && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    time_ms_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_byte(b, t, r)) frames_due.push_back(r);
  endtask

  // header, readings and checksum over bytes 0..29; data bytes already set
  task automatic seal_frame(input half_t pm25, input half_t pm10, input half_t flip);
    half_t total;
    frame_buf[0]  = HdrFirst;
    frame_buf[1]  = HdrSecond;
    frame_buf[12] = pm25[15:8];
    frame_buf[13] = pm25[7:0];
    frame_buf[14] = pm10[15:8];
    frame_buf[15] = pm10[7:0];
    total = '0;
    for (int i = 0; i < 30; i++) total = total + half_t'(frame_buf[i]);
    total = total ^ flip;
    frame_buf[30] = total[15:8];
    frame_buf[31] = total[7:0];
  endtask

  task automatic send_frame(input word_t t_last);
    for (int i = 0; i < 32; i++) push_byte(frame_buf[i], t_last - word_t'(31 - i));
  endtask

  task automatic report(input string what, input word_t want, input word_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("tb: mismatch in %s at %0t: expected %h, got %h", what, $realtime, want, got);
  endtask

  // result monitor
  always @(posedge clk_i) begin
    frame_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frames_due.size() == 0) begin
        report("unexpected transfer", '0, {31'd0, frame_good_o});
      end else begin
        want = frames_due.pop_front();
        if (frame_good_o !== want.good)
          report("frame_good", word_t'(want.good), word_t'(frame_good_o));
        if (pm25_value_o !== want.pm25)
          report("pm25_value", word_t'(want.pm25), word_t'(pm25_value_o));
        if (pm10_value_o !== want.pm10)
          report("pm10_value", word_t'(want.pm10), word_t'(pm10_value_o));
        if (packet_time_ms_o !== want.stamp)
          report("packet_time_ms", want.stamp, packet_time_ms_o);
        if (error_total_o !== want.errs) report("error_total", want.errs, error_total_o);
      end
    end
  end

  // result receiver: random stalls, quiet stretches, and one long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 37);
    end
  end

  initial begin
    frame_res_t typed_res;
    int         sent_bytes;
    int         frame_idx;
    int         noise_n;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    time_ms_i   = '0;
    out_stall_i = 1'b0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    mismatches  = 0;
    in_frame    = 1'b0;
    frame_pos   = '0;
    last_byte   = '0;
    sum_acc     = '0;
    pm25_acc    = '0;
    pm10_acc    = '0;
    sum_hi_rx   = '0;
    bad_frames  = '0;

    //          lead   fill   pm25      pm10      stamp          flip      typed good pm25 pm10 errs
    plan[0] = '{8'h3D, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, 1'b1,
                16'h0000, 16'h0000, 32'd0};
    plan[1] = '{8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b1,
                16'hFFFF, 16'hFFFF, 32'd0};
    // 0x3D right after a frame must not open one; header bytes as data
    plan[2] = '{8'h3D, 8'h32, 16'h323D, 16'h3D32, 32'h1234_5678, 16'h0000, 1'b0, 1'b0,
                16'h0000, 16'h0000, 32'd0};
    // doubled first header byte, bad checksum low byte
    plan[3] = '{8'h32, 8'h3D, 16'h1234, 16'hABCD, 32'h8000_0000, 16'h0001, 1'b1, 1'b0,
                16'h0000, 16'h0000, 32'd1};
    plan[4] = '{8'h3D, 8'hA5, 16'h5A5A, 16'hA5A5, 32'h7FFF_FFFF, 16'h0100, 1'b1, 1'b0,
                16'h0000, 16'h0000, 32'd2};
    plan[5] = '{8'h55, 8'h01, 16'h0001, 16'h8000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0,
                16'h0000, 16'h0000, 32'd3};
    plan[6] = '{8'hAA, 8'h7E, 16'h00FF, 16'hFF00, 32'hDEAD_BEEF, 16'h0000, 1'b0, 1'b0,
                16'h0000, 16'h0000, 32'd0};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PlanRows; r++) begin
      push_byte(plan[r].lead, plan[r].stamp ^ 32'h5555_5555);
      for (int i = 2; i < 30; i++) frame_buf[i] = plan[r].fill;
      seal_frame(plan[r].pm25, plan[r].pm10, plan[r].sum_flip);
      send_frame(plan[r].stamp);
      if (plan[r].typed && frames_due.size() != 0) begin
        typed_res = '{plan[r].exp_good, plan[r].exp_pm25, plan[r].exp_pm10,
                      plan[r].stamp, plan[r].exp_errs};
        frames_due[frames_due.size() - 1] = typed_res;
      end
    end

    sent_bytes = 0;
    frame_idx  = 0;
    while (sent_bytes < RandBytes) begin
      quiet = (frame_idx >= 15 && frame_idx < 25);
      if (frame_idx == 8) hold_req = 1'b1;
      if (frame_idx == 35) begin
        // sender pause until the pipe has drained
        in_valid_i <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk_i);
        repeat (4) @(posedge clk_i);
      end

      // inter-frame noise and broken headers
      noise_n = $urandom_range(0, 3);
      for (int n = 0; n < noise_n; n++)
        push_byte(($urandom_range(99) < 30) ? HdrFirst : byte_t'($urandom_range(255)),
                  word_t'($urandom));
      if ($urandom_range(99) < 10) begin
        push_byte(HdrFirst, word_t'($urandom));
        push_byte(byte_t'($urandom_range(HdrSecond + 1, 255)), word_t'($urandom));
      end

      for (int i = 2; i < 30; i++) frame_buf[i] = byte_t'($urandom_range(255));
      seal_frame(half_t'($urandom_range(65535)), half_t'($urandom_range(65535)),
                 ($urandom_range(99) < 25) ? half_t'($urandom_range(1, 65535)) : 16'h0000);
      send_frame(word_t'($urandom));
      sent_bytes += 32;
      frame_idx++;
    end

    quiet = 1'b0;
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
